// ===== rtl/slot_allocator_with_tile_chains_assert.svh =====
// Assertion macros shared by the slot allocator checker.
`ifndef SLOT_ALLOCATOR_WITH_TILE_CHAINS_ASSERT_SVH
`define SLOT_ALLOCATOR_WITH_TILE_CHAINS_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define SAT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define SAT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/sat_pkg.sv =====
// Package with types, constants and command codes of the slot allocator.
`timescale 1ns / 1ps
`default_nettype none

package sat_pkg;

	localparam int unsigned SLOTS     = 1024;
	localparam int unsigned GRID_SIDE = 64;
	localparam int unsigned CELLS     = GRID_SIDE * GRID_SIDE;
	localparam int unsigned SLOT_AW   = $clog2(SLOTS);
	localparam int unsigned CELL_AW   = $clog2(CELLS);
	localparam int unsigned CLR_LEN   = (SLOTS > CELLS) ? SLOTS : CELLS;
	localparam int unsigned CLR_AW    = $clog2(CLR_LEN);

	localparam int unsigned MODE_W   = 3;
	localparam int unsigned SLOT_W   = 10;
	localparam int unsigned TILE_W   = 6;
	localparam int unsigned STATUS_W = 2;

	typedef logic [SLOT_AW-1:0] slot_addr_t;
	typedef logic [CELL_AW-1:0] cell_addr_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_ALLOC    = 3'd0,
		MODE_FREE     = 3'd1,
		MODE_APPEND   = 3'd2,
		MODE_REMOVE   = 3'd3,
		MODE_RD_HEAD  = 3'd4,
		MODE_RD_NEXT  = 3'd5,
		MODE_WR_HEAD  = 3'd6
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_INVALID  = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [SLOT_W-1:0] slot;
		logic [TILE_W-1:0] tile_x;
		logic [TILE_W-1:0] tile_y;
	} req_t;

	typedef struct packed {
		logic [SLOT_W-1:0]   slot_out;
		logic [STATUS_W-1:0] status;
	} rsp_t;

	// Datapath operations issued by the controller, one per cycle.
	typedef enum logic [4:0] {
		OP_NONE,
		OP_CLEAR,
		OP_LOAD,
		OP_SCAN_START,
		OP_SCAN_STEP,
		OP_ALLOC,
		OP_FREE,
		OP_APPEND_HEAD,
		OP_HEAD_WRITE,
		OP_WALK_START,
		OP_WALK_STEP,
		OP_LINK_TAIL,
		OP_UNLINK_HEAD,
		OP_UNLINK_MID,
		OP_CLEAR_LINK,
		OP_RES_HEAD,
		OP_RES_NEXT,
		OP_RES_ERR
	} dp_op_t;

	typedef struct packed {
		dp_op_t  op;
		status_t err;
		logic    push;
	} dp_cmd_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              cell_ok;
		logic              slot_ok;
		logic              slot_lt;
		logic              occ;
		logic              head_zero;
		logic              head_is_slot;
		logic              nxt_zero;
		logic              nxt_is_slot;
		logic              scan_last;
		logic              step_last;
		logic              clr_last;
	} dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/sat_dp.sv =====
// Datapath of the slot allocator: slot and head memories, walk pointer, result registers.
`timescale 1ns / 1ps
`default_nettype none

module sat_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  sat_pkg::req_t     req,
	input  sat_pkg::dp_cmd_t  cmd,
	output sat_pkg::dp_stat_t stat,
	output sat_pkg::rsp_t     rsp
);
	import sat_pkg::*;

	logic       occ_mem  [SLOTS];
	slot_addr_t nxt_mem  [SLOTS];
	slot_addr_t head_mem [CELLS];

	logic       occ_rd_q;
	slot_addr_t nxt_rd_q;
	slot_addr_t head_rd_q;

	logic [MODE_W-1:0] mode_q;
	logic [SLOT_W-1:0] slot_q;
	cell_addr_t        cell_q;
	logic              cell_ok_q;

	slot_addr_t        cur_q;
	slot_addr_t        steps_q;
	slot_addr_t        nxt_slot_q;
	logic [CLR_AW-1:0] clr_q;
	slot_addr_t        res_slot_q;
	status_t           res_status_q;
	rsp_t              rsp_q;

	cell_addr_t req_cell;
	logic       req_cell_ok;
	slot_addr_t slot_addr;

	slot_addr_t occ_ra, nxt_ra;
	logic       occ_we, occ_wd;
	slot_addr_t occ_wa;
	logic       nxt_we;
	slot_addr_t nxt_wa, nxt_wd;
	logic       head_we;
	cell_addr_t head_wa;
	slot_addr_t head_wd;

	assign req_cell    = CELL_AW'(32'(req.tile_y) * GRID_SIDE + 32'(req.tile_x));
	assign req_cell_ok = (32'(req.tile_x) < GRID_SIDE) && (32'(req.tile_y) < GRID_SIDE);
	assign slot_addr   = SLOT_AW'(slot_q);

	// Read address selection
	always_comb begin
		unique case (cmd.op)
			OP_LOAD:       occ_ra = SLOT_AW'(req.slot);
			OP_SCAN_START: occ_ra = SLOT_AW'(1);
			default:       occ_ra = cur_q + SLOT_AW'(1);
		endcase
		unique case (cmd.op)
			OP_LOAD:       nxt_ra = SLOT_AW'(req.slot);
			OP_WALK_START: nxt_ra = head_rd_q;
			default:       nxt_ra = nxt_rd_q;
		endcase
	end

	// Write port selection
	always_comb begin
		occ_we  = 1'b0;
		occ_wa  = cur_q;
		occ_wd  = 1'b0;
		nxt_we  = 1'b0;
		nxt_wa  = slot_addr;
		nxt_wd  = '0;
		head_we = 1'b0;
		head_wa = cell_q;
		head_wd = slot_addr;
		unique case (cmd.op)
			OP_CLEAR: begin
				occ_we  = 1'b1;
				occ_wa  = SLOT_AW'(clr_q);
				nxt_we  = 1'b1;
				nxt_wa  = SLOT_AW'(clr_q);
				head_we = 1'b1;
				head_wa = CELL_AW'(clr_q);
				head_wd = '0;
			end
			OP_ALLOC: begin
				occ_we = 1'b1;
				occ_wd = 1'b1;
				nxt_we = 1'b1;
				nxt_wa = cur_q;
			end
			OP_FREE: begin
				occ_we = 1'b1;
				occ_wa = slot_addr;
			end
			OP_APPEND_HEAD: begin
				head_we = 1'b1;
				nxt_we  = 1'b1;
			end
			OP_HEAD_WRITE: begin
				head_we = 1'b1;
			end
			OP_LINK_TAIL: begin
				nxt_we = 1'b1;
				nxt_wa = cur_q;
				nxt_wd = slot_addr;
			end
			OP_UNLINK_HEAD: begin
				head_we = 1'b1;
				head_wd = nxt_rd_q;
				nxt_we  = 1'b1;
			end
			OP_UNLINK_MID: begin
				nxt_we = 1'b1;
				nxt_wa = cur_q;
				nxt_wd = nxt_slot_q;
			end
			OP_CLEAR_LINK: begin
				nxt_we = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (occ_we) begin
			occ_mem[occ_wa] <= occ_wd;
		end
		occ_rd_q <= occ_mem[occ_ra];
	end

	always_ff @(posedge clk) begin
		if (nxt_we) begin
			nxt_mem[nxt_wa] <= nxt_wd;
		end
		nxt_rd_q <= nxt_mem[nxt_ra];
	end

	always_ff @(posedge clk) begin
		if (head_we) begin
			head_mem[head_wa] <= head_wd;
		end
		head_rd_q <= head_mem[req_cell];
	end

	// Clear pass index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.op == OP_CLEAR) begin
			clr_q <= clr_q + CLR_AW'(1);
		end
	end

	// Item, walk and result registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				mode_q    <= req.mode;
				slot_q    <= req.slot;
				cell_q    <= req_cell;
				cell_ok_q <= req_cell_ok;
			end
			OP_SCAN_START: cur_q <= SLOT_AW'(1);
			OP_SCAN_STEP:  cur_q <= cur_q + SLOT_AW'(1);
			OP_WALK_START: begin
				cur_q      <= head_rd_q;
				steps_q    <= '0;
				nxt_slot_q <= nxt_rd_q;
			end
			OP_WALK_STEP: begin
				cur_q   <= nxt_rd_q;
				steps_q <= steps_q + SLOT_AW'(1);
			end
			OP_ALLOC: begin
				res_slot_q   <= cur_q;
				res_status_q <= ST_OK;
			end
			OP_RES_HEAD: begin
				res_slot_q   <= head_rd_q;
				res_status_q <= ST_OK;
			end
			OP_RES_NEXT: begin
				res_slot_q   <= nxt_rd_q;
				res_status_q <= ST_OK;
			end
			OP_RES_ERR: begin
				res_slot_q   <= '0;
				res_status_q <= cmd.err;
			end
			OP_FREE, OP_APPEND_HEAD, OP_HEAD_WRITE, OP_UNLINK_HEAD, OP_CLEAR_LINK: begin
				res_slot_q   <= '0;
				res_status_q <= ST_OK;
			end
			default: ;
		endcase
		if (cmd.push) begin
			rsp_q.slot_out <= SLOT_W'(res_slot_q);
			rsp_q.status   <= res_status_q;
		end
	end

	assign rsp = rsp_q;

	always_comb begin
		stat.mode         = mode_q;
		stat.cell_ok      = cell_ok_q;
		stat.slot_ok      = (slot_q != '0) && (32'(slot_q) < SLOTS);
		stat.slot_lt      = 32'(slot_q) < SLOTS;
		stat.occ          = occ_rd_q;
		stat.head_zero    = head_rd_q == '0;
		stat.head_is_slot = head_rd_q == slot_addr;
		stat.nxt_zero     = nxt_rd_q == '0;
		stat.nxt_is_slot  = nxt_rd_q == slot_addr;
		stat.scan_last    = cur_q == SLOT_AW'(SLOTS - 1);
		stat.step_last    = steps_q == SLOT_AW'(SLOTS - 1);
		stat.clr_last     = clr_q == CLR_AW'(CLR_LEN - 1);
	end

endmodule

`default_nettype wire

// ===== rtl/sat_ctrl.sv =====
// Controller state machine of the slot allocator.
`timescale 1ns / 1ps
`default_nettype none

module sat_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	input  sat_pkg::dp_stat_t stat,
	output sat_pkg::dp_cmd_t  cmd
);
	import sat_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_WALK_APP,
		S_WALK_REM,
		S_LINK_SLOT,
		S_FINISH
	} state_t;

	state_t state_q, state_d;
	logic   rsp_valid_q;
	logic   need_cell;

	assign need_cell = (stat.mode == MODE_APPEND) || (stat.mode == MODE_REMOVE) ||
	                   (stat.mode == MODE_RD_HEAD) || (stat.mode == MODE_WR_HEAD);

	always_comb begin
		cmd.op   = OP_NONE;
		cmd.err  = ST_OK;
		cmd.push = 1'b0;
		state_d  = state_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.op = OP_CLEAR;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.op  = OP_LOAD;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_FINISH;
				if (need_cell && !stat.cell_ok) begin
					cmd.op  = OP_RES_ERR;
					cmd.err = ST_INVALID;
				end else begin
					unique case (stat.mode)
						MODE_ALLOC: begin
							cmd.op  = OP_SCAN_START;
							state_d = S_SCAN;
						end
						MODE_FREE: begin
							if (stat.slot_ok) begin
								cmd.op = OP_FREE;
							end else begin
								cmd.op  = OP_RES_ERR;
								cmd.err = ST_INVALID;
							end
						end
						MODE_APPEND: begin
							if (!stat.slot_ok || !stat.occ) begin
								cmd.op  = OP_RES_ERR;
								cmd.err = ST_INVALID;
							end else if (stat.head_zero) begin
								cmd.op = OP_APPEND_HEAD;
							end else begin
								cmd.op  = OP_WALK_START;
								state_d = S_WALK_APP;
							end
						end
						MODE_REMOVE: begin
							if (!stat.slot_ok || !stat.occ) begin
								cmd.op  = OP_RES_ERR;
								cmd.err = ST_INVALID;
							end else if (stat.head_zero) begin
								cmd.op  = OP_RES_ERR;
								cmd.err = ST_NOTFOUND;
							end else if (stat.head_is_slot) begin
								cmd.op = OP_UNLINK_HEAD;
							end else begin
								cmd.op  = OP_WALK_START;
								state_d = S_WALK_REM;
							end
						end
						MODE_RD_HEAD: cmd.op = OP_RES_HEAD;
						MODE_RD_NEXT: begin
							if (stat.slot_ok) begin
								cmd.op = OP_RES_NEXT;
							end else begin
								cmd.op  = OP_RES_ERR;
								cmd.err = ST_INVALID;
							end
						end
						MODE_WR_HEAD: begin
							if (stat.slot_lt) begin
								cmd.op = OP_HEAD_WRITE;
							end else begin
								cmd.op  = OP_RES_ERR;
								cmd.err = ST_INVALID;
							end
						end
						default: begin
							cmd.op  = OP_RES_ERR;
							cmd.err = ST_INVALID;
						end
					endcase
				end
			end
			S_SCAN: begin
				if (!stat.occ) begin
					cmd.op  = OP_ALLOC;
					state_d = S_FINISH;
				end else if (stat.scan_last) begin
					cmd.op  = OP_RES_ERR;
					cmd.err = ST_FULL;
					state_d = S_FINISH;
				end else begin
					cmd.op = OP_SCAN_STEP;
				end
			end
			S_WALK_APP: begin
				if (stat.nxt_zero) begin
					cmd.op  = OP_LINK_TAIL;
					state_d = S_LINK_SLOT;
				end else if (stat.step_last) begin
					cmd.op  = OP_RES_ERR;
					cmd.err = ST_NOTFOUND;
					state_d = S_FINISH;
				end else begin
					cmd.op = OP_WALK_STEP;
				end
			end
			S_WALK_REM: begin
				if (stat.nxt_zero || (!stat.nxt_is_slot && stat.step_last)) begin
					cmd.op  = OP_RES_ERR;
					cmd.err = ST_NOTFOUND;
					state_d = S_FINISH;
				end else if (stat.nxt_is_slot) begin
					cmd.op  = OP_UNLINK_MID;
					state_d = S_LINK_SLOT;
				end else begin
					cmd.op = OP_WALK_STEP;
				end
			end
			S_LINK_SLOT: begin
				cmd.op  = OP_CLEAR_LINK;
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (!rsp_valid_q || rsp_ready) begin
					cmd.push = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rsp_valid_q <= cmd.push | (rsp_valid_q & ~rsp_ready);
		end
	end

	assign req_ready = state_q == S_IDLE;
	assign rsp_valid = rsp_valid_q;

endmodule

`default_nettype wire

// ===== rtl/slot_allocator_with_tile_chains.sv =====
// Top level of the slot allocator with per-cell linked chains.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+--------------------------------
//   req     | in        | req_valid / req_ready  | mode, slot, tile_x, tile_y
//   rsp     | out       | rsp_valid / rsp_ready  | slot_out, status
//
// One transaction is in work at a time. Every transaction settled at decode (free,
// reads, write head, append to an empty chain, remove of the head, early errors)
// passes from acceptance through decode and the final step back to idle.
// Allocate scans slot by slot from slot 1 up to and including the free one (up to
// SLOTS - 1 slots), since the occupied memory gives one bit a cycle. Append and
// remove that walk a chain read one next link per step (up to SLOTS links), plus a
// step to clear the moved slot's link when the walk ends in a relink.
// After reset a clearing pass over max(SLOTS, GRID_SIDE * GRID_SIDE) addresses (4096)
// zeroes all memories before req_ready rises.
// A stalled rsp holds in its output register; the block finishes the next
// transaction and waits in its final step until the register frees.
`timescale 1ns / 1ps
`default_nettype none

module slot_allocator_with_tile_chains (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  sat_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output sat_pkg::rsp_t rsp
);
	import sat_pkg::*;

	// Commands flow from the controller to the datapath, status flows back.
	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Controller: sequences the clear pass, decode, scan and chain walks,
	// and owns the response valid flag.
	sat_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Datapath: occupied, next-link and cell-head memories, walk pointer,
	// result and output registers.
	sat_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire

// ===== rtl/sat_checker.sv =====
// Port-level checker for the slot allocator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "slot_allocator_with_tile_chains_assert.svh"

module sat_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input sat_pkg::rsp_t rsp
);
	import sat_pkg::*;

	// Hold a stalled response.
	`SAT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "rsp changed while stalled")

	// Drop ready after acceptance: one transaction at a time.
	`SAT_ASSERT_NEXT(a_single_item, req_valid && req_ready, !req_ready, "ready held after accept")

	// Error results carry no slot.
	`SAT_ASSERT_NOW(a_err_slot_zero, rsp_valid && (rsp.status != ST_OK), rsp.slot_out == '0, "error with slot")

	// A new response comes only out of a busy cycle.
	`SAT_ASSERT_NOW(a_rsp_from_busy, $rose(rsp_valid), $past(!req_ready), "rsp raised while idle")

endmodule

bind slot_allocator_with_tile_chains sat_checker u_sat_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

`default_nettype wire
